// ===== src/hmcd_pkg.sv =====
package hmcd_pkg;

	localparam int LENGTH_BITS_DEF = 24;
	localparam int OUT_BITS        = 24;
	localparam int NAME_LEN        = 16;
	localparam int END_LEN         = 4;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_C     = 8'h43;

	localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

	typedef enum logic [1:0] {
		PH_NONE,  // no length field found yet
		PH_SKIP,  // skipping leading whitespace
		PH_NUM,   // in sign or digits
		PH_DONE   // value finished
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first;
	} in_t;

	typedef struct packed {
		logic                complete;
		logic                header_done;
		logic [OUT_BITS-1:0] expected_total;
	} out_t;

	// "Content-Length: "
	function automatic logic [7:0] name_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h43; // C
			4'd1:    c = 8'h6F; // o
			4'd2:    c = 8'h6E; // n
			4'd3:    c = 8'h74; // t
			4'd4:    c = 8'h65; // e
			4'd5:    c = 8'h6E; // n
			4'd6:    c = 8'h74; // t
			4'd7:    c = 8'h2D; // -
			4'd8:    c = 8'h4C; // L
			4'd9:    c = 8'h65; // e
			4'd10:   c = 8'h6E; // n
			4'd11:   c = 8'h67; // g
			4'd12:   c = 8'h74; // t
			4'd13:   c = 8'h68; // h
			4'd14:   c = 8'h3A; // :
			default: c = CH_SP;
		endcase
		return c;
	endfunction

	// CR LF CR LF
	function automatic logic [7:0] end_char(input logic [1:0] idx);
		return idx[0] ? CH_LF : CH_CR;
	endfunction

endpackage

// ===== src/http_message_completeness_detector_core.sv =====
// HTTP Content-Length framing detector. One byte of the message is taken per
// request, with a first flag that starts a new message, and every byte yields
// exactly one result: header_done once the first CR LF CR LF has been seen,
// expected_total (header end + 4 + Content-Length, clamped to the length
// range and to 24 bits, 0 while the header is still open) and complete when
// the byte count has reached that total. Only the first case-sensitive
// "Content-Length: " that starts inside the header counts; its value is
// parsed like atoi (whitespace, optional sign, digits, saturating) and is
// frozen at the header end. A message without the field is complete at the
// header end. Throughput is one byte per clock while results are taken: the
// whole per-byte update is a single registered pass from the matcher and
// counter registers to the result register. A new byte is taken while a
// result waits as long as that result is being taken in the same cycle.
module http_message_completeness_detector_core
	import hmcd_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  in_t  item,
	output logic result_valid,
	input  logic result_ready,
	output out_t result
);

	localparam int LB = LENGTH_BITS;
	localparam int TW = (LB > OUT_BITS) ? LB : OUT_BITS;
	localparam logic [LB-1:0] LMAX = '1;

	// Message state.
	logic [LB-1:0] byte_count_q;
	logic [1:0]    end_prog_q;
	logic [LB-1:0] hdr_base_q;   // header end + 4, clamped
	logic          header_seen_q;
	logic [3:0]    name_prog_q;
	phase_t        phase_q;
	logic [LB-1:0] length_q;
	logic          negative_q;

	logic result_valid_q;
	out_t result_q;

	logic accept;

	// State as seen by this byte (cleared by the first flag).
	logic [LB-1:0] cnt_c, base_c, len_c;
	logic [1:0]    endp_c;
	logic [3:0]    namep_c;
	logic          hs_c, neg_c;
	phase_t        ph_c;

	// Next state.
	logic [LB-1:0] cnt_n, base_n, len_n;
	logic [1:0]    endp_n;
	logic [3:0]    namep_n;
	logic          hs_n, neg_n;
	phase_t        ph_n;

	logic [7:0]    b;
	logic          is_digit, is_ws;
	logic [LB+3:0] acc;
	logic [LB-1:0] digit_val;

	out_t          res_n;

	assign accept     = item_valid && item_ready;
	assign item_ready = !result_valid_q || result_ready;

	assign b        = item.data_byte;
	assign is_digit = b inside {[CH_0:CH_9]};
	assign is_ws    = b inside {CH_SP, [CH_TAB:CH_CR]};

	// length*10 + digit, saturating at the length range
	assign acc = {1'b0, len_c, 3'b000} + {3'b000, len_c, 1'b0} + (LB+4)'(b - CH_0);
	assign digit_val = (acc > {4'b0000, LMAX}) ? LMAX : acc[LB-1:0];

	always_comb begin
		if (item.first) begin
			cnt_c   = '0;
			base_c  = '0;
			len_c   = '0;
			endp_c  = '0;
			namep_c = '0;
			hs_c    = 1'b0;
			neg_c   = 1'b0;
			ph_c    = PH_NONE;
		end else begin
			cnt_c   = byte_count_q;
			base_c  = hdr_base_q;
			len_c   = length_q;
			endp_c  = end_prog_q;
			namep_c = name_prog_q;
			hs_c    = header_seen_q;
			neg_c   = negative_q;
			ph_c    = phase_q;
		end
	end

	// Next-state logic
	always_comb begin
		cnt_n   = (cnt_c == LMAX) ? LMAX : cnt_c + 1'b1;
		base_n  = base_c;
		len_n   = len_c;
		endp_n  = endp_c;
		namep_n = namep_c;
		hs_n    = hs_c;
		neg_n   = neg_c;
		ph_n    = ph_c;

		if (!hs_c) begin
			// name matcher runs until the field is found, then the value parser
			case (ph_c)
				PH_NONE: begin
					if (b == name_char(namep_c)) begin
						if (namep_c == 4'(NAME_LEN - 1)) begin
							ph_n    = PH_SKIP;
							namep_n = '0;
						end else begin
							namep_n = namep_c + 1'b1;
						end
					end else begin
						namep_n = (b == CH_C) ? 4'd1 : 4'd0;
					end
				end
				PH_SKIP: begin
					if (!is_ws) begin
						if (b == CH_PLUS) begin
							ph_n = PH_NUM;
						end else if (b == CH_MINUS) begin
							neg_n = 1'b1;
							ph_n  = PH_NUM;
						end else if (is_digit) begin
							len_n = digit_val;
							ph_n  = PH_NUM;
						end else begin
							ph_n = PH_DONE;
						end
					end
				end
				PH_NUM: begin
					if (is_digit) begin
						len_n = digit_val;
					end else begin
						ph_n = PH_DONE;
					end
				end
				default: begin
				end
			endcase

			// terminator matcher; the byte at position pos ends it at pos-3
			if (b == end_char(endp_c)) begin
				if (endp_c == 2'(END_LEN - 1)) begin
					hs_n = 1'b1;
					if (cnt_c == LMAX) begin
						base_n = LMAX;
					end else if (cnt_c < LB'(3)) begin
						base_n = LB'(END_LEN);
					end else begin
						base_n = cnt_c + 1'b1;
					end
				end else begin
					endp_n = endp_c + 1'b1;
				end
			end else begin
				endp_n = (b == CH_CR) ? 2'd1 : 2'd0;
			end
		end
	end

	// Result logic. The byte that closes the header is LF, never a digit, so
	// the length used here is the value before this byte.
	logic [LB:0]   sum;
	logic [LB-1:0] total;
	logic [TW-1:0] total_w;

	always_comb begin
		sum   = {1'b0, base_n} + {1'b0, len_c};
		total = base_n;
		res_n = '0;
		if (hs_n) begin
			if (ph_n != PH_NONE) begin
				if (neg_n) begin
					total = (base_n > len_c) ? base_n - len_c : '0;
				end else begin
					total = sum[LB] ? LMAX : sum[LB-1:0];
				end
				res_n.complete = (cnt_n >= total);
			end else begin
				res_n.complete = 1'b1;
			end
			res_n.header_done = 1'b1;
		end else begin
			total = '0;
		end
		total_w = TW'(total);
		res_n.expected_total = (total_w > TW'(OUT_MAX)) ? OUT_MAX : total_w[OUT_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			end_prog_q    <= '0;
			hdr_base_q    <= '0;
			header_seen_q <= 1'b0;
			name_prog_q   <= '0;
			phase_q       <= PH_NONE;
			length_q      <= '0;
			negative_q    <= 1'b0;
		end else if (accept) begin
			byte_count_q  <= cnt_n;
			end_prog_q    <= endp_n;
			hdr_base_q    <= base_n;
			header_seen_q <= hs_n;
			name_prog_q   <= namep_n;
			phase_q       <= ph_n;
			length_q      <= len_n;
			negative_q    <= neg_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= res_n;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// An open header never reports completion or a total.
	a_open_header: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.header_done |-> !result.complete && result.expected_total == '0)
		else $error("result complete or nonzero total before header end");

	// Once the header has ended it stays ended for the rest of the message.
	a_header_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !item.first && header_seen_q |=> result.header_done)
		else $error("header_done dropped within a message");

	// The byte count never moves backward within a message.
	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !item.first |=> byte_count_q > $past(byte_count_q) || byte_count_q == LMAX)
		else $error("byte count did not advance");

	// No field found means complete whenever the header has ended.
	a_no_field: assert property (@(posedge clk) disable iff (!arst_n)
		accept && hs_n && ph_n == PH_NONE |=> result.complete)
		else $error("message without length field not complete at header end");

endmodule

// ===== tb/http_message_completeness_detector_core_tb.sv =====
module http_message_completeness_detector_core_tb;
	import hmcd_pkg::*;

	// Length range of the instance under test (default parameter).
	localparam int          LEN_BITS   = LENGTH_BITS_DEF;
	localparam logic [63:0] LEN_MAX    = (64'd1 << LEN_BITS) - 64'd1;
	localparam int          REQ_TARGET = 1700;
	localparam int          PAUSE_AT   = 1100;
	localparam int          HOLD_AT    = 700;
	localparam int          HOLD_LEN   = 300;

	// Header field name and terminator, first byte in the top bits.
	localparam logic [127:0] LEN_TAG_TEXT = "Content-Length: ";
	localparam logic [31:0]  HDR_END    = {CH_CR, CH_LF, CH_CR, CH_LF};
	localparam logic [7:0]   CH_VT      = 8'h0B;
	localparam logic [7:0]   CH_FF      = 8'h0C;

	// One pending request; wait_idle holds it back until every result is in.
	typedef struct packed {
		in_t  req;
		logic wait_idle;
	} stim_t;

	logic clk;
	logic arst_n       = 1'b0;
	logic item_valid   = 1'b0;
	logic item_ready;
	in_t  item         = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	out_t result;

	http_message_completeness_detector_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Framing predictor: own copy of the per-message scan state
	// ------------------------------------------------------------------
	// Starts out as after reset, since the first message has no start flag.
	logic [LEN_BITS-1:0] msg_bytes  = '0;
	logic [2:0]          crlf_match = '0;
	logic [LEN_BITS-1:0] hdr_end    = '0;
	logic                hdr_seen   = 1'b0;
	logic [4:0]          name_match = '0;
	phase_t              len_phase  = PH_NONE;
	logic [LEN_BITS-1:0] len_mag    = '0;
	logic                len_neg    = 1'b0;

	out_t frames_q[$];     // expected results, oldest first

	function automatic bit is_space(logic [7:0] b);
		return b == CH_SP || (b >= CH_TAB && b <= CH_CR);
	endfunction

	function automatic bit is_digit(logic [7:0] b);
		return b >= CH_0 && b <= CH_9;
	endfunction

	// Decimal accumulate, saturating at the top of the length range.
	function automatic logic [63:0] add_decimal(logic [63:0] mag, logic [7:0] b);
		logic [63:0] d;
		d = 64'(b - CH_0);
		if (mag > (LEN_MAX - d) / 64'd10)
			return LEN_MAX;
		return mag * 64'd10 + d;
	endfunction

	function automatic out_t frame_predict(in_t req);
		logic [7:0]  b;
		logic [63:0] pos;
		logic [63:0] base;
		logic [63:0] total;
		out_t        res;
		b = req.data_byte;
		if (req.first) begin
			msg_bytes  = '0;
			crlf_match = '0;
			hdr_end    = '0;
			hdr_seen   = 1'b0;
			name_match = '0;
			len_phase  = PH_NONE;
			len_mag    = '0;
			len_neg    = 1'b0;
		end
		pos = 64'(msg_bytes);
		if (64'(msg_bytes) < LEN_MAX)
			msg_bytes = msg_bytes + 1'b1;
		total = '0;
		res   = '0;

		// Field and value scanning only while the header is open.
		if (!hdr_seen) begin
			if (len_phase == PH_NONE) begin
				if (name_match < NAME_LEN && b == LEN_TAG_TEXT[127 - 8*name_match -: 8])
					name_match = name_match + 1'b1;
				else
					name_match = (b == CH_C) ? 5'd1 : 5'd0;
				if (name_match >= NAME_LEN) begin
					len_phase  = PH_SKIP;
					name_match = '0;
				end
			end else if (len_phase == PH_SKIP) begin
				if (!is_space(b)) begin
					if (b == CH_PLUS) begin
						len_phase = PH_NUM;
					end else if (b == CH_MINUS) begin
						len_neg   = 1'b1;
						len_phase = PH_NUM;
					end else if (is_digit(b)) begin
						len_mag   = LEN_BITS'(add_decimal(64'(len_mag), b));
						len_phase = PH_NUM;
					end else begin
						len_phase = PH_DONE;
					end
				end
			end else if (len_phase == PH_NUM) begin
				if (is_digit(b))
					len_mag = LEN_BITS'(add_decimal(64'(len_mag), b));
				else
					len_phase = PH_DONE;
			end

			if (crlf_match < 3'd4 && b == HDR_END[31 - 8*crlf_match -: 8])
				crlf_match = crlf_match + 1'b1;
			else
				crlf_match = (b == CH_CR) ? 3'd1 : 3'd0;
			if (crlf_match >= 3'd4) begin
				hdr_seen = 1'b1;
				hdr_end  = (pos >= 64'd3) ? LEN_BITS'(pos - 64'd3) : '0;
			end
		end

		if (hdr_seen) begin
			base = 64'(hdr_end) + 64'd4;
			if (base > LEN_MAX)
				base = LEN_MAX;
			if (len_phase != PH_NONE) begin
				if (len_neg) begin
					total = (base > 64'(len_mag)) ? base - 64'(len_mag) : 64'd0;
				end else begin
					total = base + 64'(len_mag);
					if (total > LEN_MAX)
						total = LEN_MAX;
				end
				res.complete = 64'(msg_bytes) >= total;
			end else begin
				// no length field: complete right at the header end
				total        = base;
				res.complete = 1'b1;
			end
			if (total > 64'(OUT_MAX))
				total = 64'(OUT_MAX);
		end
		res.header_done    = hdr_seen;
		res.expected_total = total[OUT_BITS-1:0];
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus construction
	// ------------------------------------------------------------------
	stim_t stim_q[$];
	int    stim_total = 0;
	int    msgs_built = 0;
	bit    new_msg    = 1'b0;   // next byte opens a message
	bit    pause_next = 1'b0;   // next byte waits for the block to drain

	task automatic push_byte(logic [7:0] b);
		stim_t s;
		s.req.data_byte = b;
		s.req.first     = new_msg;
		s.wait_idle     = pause_next;
		new_msg         = 1'b0;
		pause_next      = 1'b0;
		stim_q.push_back(s);
		stim_total++;
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic push_crlf();
		push_byte(CH_CR);
		push_byte(CH_LF);
	endtask

	task automatic push_word(int n);
		repeat (n) begin
			if ($urandom_range(0, 1))
				push_byte(8'(8'h41 + $urandom_range(0, 25)));
			else
				push_byte(8'(8'h61 + $urandom_range(0, 25)));
		end
	endtask

	task automatic push_headers(int n);
		repeat (n) begin
			push_text("X-");
			push_word($urandom_range(1, 6));
			push_text(": ");
			push_word($urandom_range(1, 8));
			push_crlf();
		end
	endtask

	task automatic push_body(int n);
		repeat (n)
			push_byte(8'($urandom_range(0, 255)));
	endtask

	// Mostly blanks and tabs; CR and LF only now and then since they feed
	// the terminator matcher too.
	function automatic logic [7:0] pick_space();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)  return CH_SP;
		if (r < 7)  return CH_TAB;
		if (r == 7) return CH_VT;
		if (r == 8) return CH_FF;
		return $urandom_range(0, 1) ? CH_CR : CH_LF;
	endfunction

	// Value text after the field name. wild marks values whose body length
	// is not worth matching (negative or huge).
	task automatic push_value(output int val, output bit wild);
		int r;
		val  = 0;
		wild = 1'b0;
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) push_byte(pick_space());
		r = $urandom_range(0, 19);
		if (r < 3) begin
			push_byte(CH_PLUS);
		end else if (r < 6) begin
			push_byte(CH_MINUS);
			wild = 1'b1;
		end
		r = $urandom_range(0, 19);
		if (r == 0) begin
			// no digits at all: value stays zero
		end else if (r == 1) begin
			// long digit run, usually past the saturation point
			push_byte(8'(8'h31 + $urandom_range(0, 8)));
			repeat ($urandom_range(7, 10)) push_byte(8'(CH_0 + $urandom_range(0, 9)));
			wild = 1'b1;
		end else begin
			val = $urandom_range(0, 40);
			if ($urandom_range(0, 7) == 0)
				push_byte(CH_0);
			push_text($sformatf("%0d", val));
		end
	endtask

	task automatic build_message();
		int kind;
		int val;
		int blen;
		int r;
		bit wild;
		new_msg = 1'b1;
		msgs_built++;
		kind = $urandom_range(0, 9);
		if (kind != 7 && $urandom_range(0, 3) != 0)
			push_text("POST /x HTTP/1.1");
		if (kind != 7 && kind != 8)
			push_crlf();
		case (kind)
			0, 1, 2, 3, 4: begin
				// well-formed header carrying the length field
				push_headers($urandom_range(0, 2));
				push_text("Content-Length: ");
				push_value(val, wild);
				push_crlf();
				push_headers($urandom_range(0, 1));
				push_crlf();
				r = $urandom_range(0, 9);
				if (wild)
					blen = $urandom_range(0, 6);
				else if (r == 0)
					blen = (val > 0) ? val - 1 : 0;
				else if (r == 1)
					blen = val + $urandom_range(1, 3);
				else
					blen = val;
				push_body(blen);
			end
			5: begin
				// no length field
				push_headers($urandom_range(0, 2));
				push_crlf();
				push_body($urandom_range(0, 6));
			end
			6: begin
				// near misses on the field name, or a value after the header end
				case ($urandom_range(0, 4))
					0: push_text("Content-length: 5");
					1: push_text("Content-Length:5");
					2: push_text("CContent-Length: 7");
					3: push_text("Content-Lengt");
					default: begin
						push_text("Content-Length: ");
						push_crlf();
						push_crlf();
						push_text("12");
					end
				endcase
				push_crlf();
				push_crlf();
				push_body($urandom_range(0, 5));
			end
			7: begin
				// noise heavy in CR, LF and C
				repeat ($urandom_range(1, 24)) begin
					r = $urandom_range(0, 19);
					if (r < 5)       push_byte(CH_CR);
					else if (r < 8)  push_byte(CH_LF);
					else if (r < 10) push_byte(CH_C);
					else             push_byte(8'($urandom_range(0, 255)));
				end
			end
			8: begin
				// terminator first; a field in the body must not count
				push_crlf();
				push_crlf();
				push_text("Content-Length: 3");
				push_crlf();
				push_body($urandom_range(0, 4));
			end
			default: begin
				// junk inside the value, then a second field that is ignored
				push_text("Content-Length: ");
				push_value(val, wild);
				push_word(1);
				push_text("7");
				push_crlf();
				push_text("Content-Length: 99");
				push_crlf();
				push_crlf();
				push_body(wild ? $urandom_range(0, 4) : val);
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Request driver: changes inputs on the falling edge
	// ------------------------------------------------------------------
	logic  req_taken = 1'b0;   // request accepted at the last rising edge
	int    send_gap  = 0;
	bit    tx_steady = 1'b0;
	stim_t cur_stim;

	// Mostly short idle gaps, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			if (item_valid && !req_taken) begin
				// request still offered, payload held
			end else if (send_gap > 0) begin
				send_gap--;
				item_valid <= 1'b0;
			end else if (stim_q.size() != 0 &&
			             !(stim_q[0].wait_idle && frames_q.size() != 0)) begin
				cur_stim = stim_q.pop_front();
				item       <= cur_stim.req;
				item_valid <= 1'b1;
				if ($urandom_range(0, 149) == 0)
					tx_steady = !tx_steady;
				send_gap = tx_steady ? 0 : pick_gap();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: random back-pressure plus one long hold-off
	// ------------------------------------------------------------------
	int rx_gap    = 0;
	int rx_hold   = 0;
	bit rx_steady = 1'b0;
	bit hold_done = 1'b0;
	int reqs_sent = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			// long stall while the sender keeps offering: fills the block
			if (!hold_done && reqs_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				rx_hold   = HOLD_LEN;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				result_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				if ($urandom_range(0, 149) == 0)
					rx_steady = !rx_steady;
				rx_gap = rx_steady ? 0 : pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor and checker: samples on the rising edge
	// ------------------------------------------------------------------
	int   results_seen = 0;
	int   done_seen    = 0;
	int   hdr_results  = 0;
	int   err_cnt      = 0;
	out_t want_res;

	function automatic string fmt_res(out_t r);
		return $sformatf("complete=%0b header_done=%0b expected_total=%0d",
		                 r.complete, r.header_done, r.expected_total);
	endfunction

	// Only the first ten failures are printed; the rest are counted.
	task automatic flag_error(string what);
		err_cnt++;
		if (err_cnt <= 10)
			$display("ERROR at %0t: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		// result side first: it always belongs to an older request
		if (result_valid && result_ready) begin
			results_seen++;
			if (frames_q.size() == 0) begin
				flag_error($sformatf("result %0d with nothing expected: %s",
				                     results_seen, fmt_res(result)));
			end else begin
				want_res = frames_q.pop_front();
				if (result.complete !== want_res.complete ||
				    result.header_done !== want_res.header_done ||
				    result.expected_total !== want_res.expected_total)
					flag_error($sformatf("result %0d: expected %s, got %s", results_seen,
					                     fmt_res(want_res), fmt_res(result)));
				if (want_res.complete)
					done_seen++;
				if (want_res.header_done)
					hdr_results++;
			end
		end
		if (item_valid && item_ready) begin
			frames_q.push_back(frame_predict(item));
			reqs_sent++;
		end
		req_taken <= item_valid && item_ready;
	end

	// ------------------------------------------------------------------
	// Sequence: build stimulus, reset, run, drain, report
	// ------------------------------------------------------------------
	initial begin
		// Directed: first message without the start flag (state comes from
		// reset), a short complete body, then a zero byte and an all-ones byte.
		push_text("Content-Length: 2");
		push_crlf();
		push_crlf();
		push_text("ab");
		new_msg = 1'b1;
		push_byte(8'h00);
		push_byte(8'hFF);

		// Random messages; the first one and any that start within 60 requests after PAUSE_AT wait for a drain.
		pause_next = 1'b1;
		while (stim_total < REQ_TARGET) begin
			if (stim_total >= PAUSE_AT && stim_total < PAUSE_AT + 60)
				pause_next = 1'b1;
			build_message();
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (reqs_sent < stim_total)
			@(posedge clk);
		while (frames_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		// two directed messages ahead of the random ones
		$display("covered %0d requests in %0d messages under random stalls",
		         reqs_sent, msgs_built + 2);
		$display("%0d results, %0d after header end, %0d complete",
		         results_seen, hdr_results, done_seen);
		$display("mismatches: %0d", err_cnt);
		if (err_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#6000000;
		$display("timeout: %0d requests sent, %0d results, %0d still expected",
		         reqs_sent, results_seen, frames_q.size());
		$display("status: fail");
		$finish;
	end

endmodule
